### hw/rtl/iiav_pkg.sv
package iiav_pkg;

    // Store geometry.
    localparam int MAX_HEIGHT   = 128;
    localparam int MAX_WIDTH    = 128;
    localparam int MAX_CHANNELS = 4;

    localparam int ROW_W       = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int COL_W       = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CH_W        = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int STORE_DEPTH = MAX_CHANNELS * MAX_HEIGHT * MAX_WIDTH;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // Field widths of the stream beats.
    localparam int WORD_W  = 32;
    localparam int POS_W   = 7;
    localparam int CHIN_W  = 2;
    localparam int VAL_LSB = 0;
    localparam int ROW_LSB = VAL_LSB + WORD_W;
    localparam int COL_LSB = ROW_LSB + POS_W;
    localparam int CH_LSB  = COL_LSB + POS_W;
    localparam int S_DATA_W = 48;
    localparam int MEAN_W   = 41;
    localparam int M_DATA_W = 48;

    // Configuration registers.
    localparam int REG_W       = 8;
    localparam int CHANS_W     = 3;
    localparam int CFG_IDX_W   = 2;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CELL     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 2'd3;
    localparam logic [REG_W-1:0]   HEIGHT_RESET   = 8'd128;
    localparam logic [REG_W-1:0]   WIDTH_RESET    = 8'd128;
    localparam logic [REG_W-1:0]   CELL_RESET     = 8'd8;
    localparam logic [CHANS_W-1:0] CHANNELS_RESET = 3'd1;

    // Arithmetic widths.
    localparam int PROD_W = 16;
    localparam int SUM_W  = 35;
    localparam int FRAC_W = 8;
    localparam int QUO_W  = 42;
    localparam int DEN_W  = 16;
    localparam int STEP_W = $clog2(QUO_W / 2 + 1);

    localparam logic [QUO_W-1:0] MAG_POS_LIM = QUO_W'((64'd1 << (MEAN_W - 1)) - 64'd1);
    localparam logic [QUO_W-1:0] MAG_NEG_LIM = QUO_W'(64'd1 << (MEAN_W - 1));
    localparam logic signed [MEAN_W-1:0] MEAN_MAX = {1'b0, {(MEAN_W - 1){1'b1}}};
    localparam logic signed [MEAN_W-1:0] MEAN_MIN = {1'b1, {(MEAN_W - 1){1'b0}}};

    // Command queue.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        KIND_WRITE,
        KIND_QUERY,
        KIND_EMPTY
    } kind_t;

    typedef struct packed {
        logic [REG_W-1:0]   height;
        logic [REG_W-1:0]   width;
        logic [REG_W-1:0]   cell_size;
        logic [CHANS_W-1:0] chans;
    } cfg_t;

    typedef struct packed {
        kind_t             kind;
        logic [CH_W-1:0]   ch;
        logic [ROW_W-1:0]  top;
        logic [ROW_W-1:0]  bottom;
        logic [COL_W-1:0]  left;
        logic [COL_W-1:0]  right;
        logic [WORD_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic                    valid;
        logic                    empty;
        logic signed [SUM_W-1:0] sum;
    } div_req_t;

    function automatic logic [ADDR_W-1:0] store_addr(
        input logic [CH_W-1:0]  ch,
        input logic [ROW_W-1:0] row,
        input logic [COL_W-1:0] col
    );
        logic [ADDR_W-1:0] a;
        a = ADDR_W'(ch) * ADDR_W'(MAX_HEIGHT) + ADDR_W'(row);
        a = a * ADDR_W'(MAX_WIDTH) + ADDR_W'(col);
        return a;
    endfunction

endpackage

### hw/rtl/iiav_ram.sv
module iiav_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_reg[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/iiav_front.sv
module iiav_front
    import iiav_pkg::*;
(
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                s_tuser,
    input  cfg_t                cfg,
    input  logic                q_full,
    output logic                q_push,
    output cmd_t                q_item
);

    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
    logic [CHIN_W-1:0] ch;
    logic [PROD_W-1:0] row_w;
    logic [PROD_W-1:0] col_w;
    logic [PROD_W-1:0] ch_w;
    logic [PROD_W-1:0] cell_w;
    logic [PROD_W-1:0] h_w;
    logic [PROD_W-1:0] w_w;
    logic [PROD_W-1:0] nch_w;
    logic [PROD_W-1:0] top_w;
    logic [PROD_W-1:0] left_w;
    logic [PROD_W-1:0] bot_edge;
    logic [PROD_W-1:0] right_edge;
    logic [PROD_W-1:0] h_last;
    logic [PROD_W-1:0] w_last;
    logic [PROD_W-1:0] bottom_w;
    logic [PROD_W-1:0] right_w;
    logic [PROD_W-1:0] row_sel;
    logic [PROD_W-1:0] col_sel;
    logic              is_query;
    logic              in_store;
    logic              in_grid;

    assign row      = s_tdata[ROW_LSB +: POS_W];
    assign col      = s_tdata[COL_LSB +: POS_W];
    assign ch       = s_tdata[CH_LSB +: CHIN_W];
    assign is_query = s_tuser;

    assign row_w  = PROD_W'(row);
    assign col_w  = PROD_W'(col);
    assign ch_w   = PROD_W'(ch);
    assign cell_w = PROD_W'(cfg.cell_size);

    // Oversized geometry registers are clamped to the store dimensions.
    assign h_w   = (PROD_W'(cfg.height) > PROD_W'(MAX_HEIGHT)) ?
                   PROD_W'(MAX_HEIGHT) : PROD_W'(cfg.height);
    assign w_w   = (PROD_W'(cfg.width) > PROD_W'(MAX_WIDTH)) ?
                   PROD_W'(MAX_WIDTH) : PROD_W'(cfg.width);
    assign nch_w = (PROD_W'(cfg.chans) > PROD_W'(MAX_CHANNELS)) ?
                   PROD_W'(MAX_CHANNELS) : PROD_W'(cfg.chans);

    assign top_w      = row_w * cell_w;
    assign left_w     = col_w * cell_w;
    assign bot_edge   = top_w + cell_w;
    assign right_edge = left_w + cell_w;
    assign h_last     = h_w - PROD_W'(1);
    assign w_last     = w_w - PROD_W'(1);
    assign bottom_w   = (bot_edge <= h_last) ? bot_edge : h_last;
    assign right_w    = (right_edge <= w_last) ? right_edge : w_last;

    // A cell row r lies in the grid of ceil(h/c)-1 rows exactly when (r+1)*c < h.
    assign in_grid = (cell_w != '0) && (bot_edge < h_w) && (right_edge < w_w) &&
                     (ch_w < nch_w);

    assign in_store = (row_w < PROD_W'(MAX_HEIGHT)) && (col_w < PROD_W'(MAX_WIDTH)) &&
                      (ch_w < PROD_W'(MAX_CHANNELS));

    assign row_sel = is_query ? top_w : row_w;
    assign col_sel = is_query ? left_w : col_w;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full && (is_query || in_store);

    always_comb
    begin
        q_item.kind   = is_query ? (in_grid ? KIND_QUERY : KIND_EMPTY) : KIND_WRITE;
        q_item.ch     = ch_w[CH_W-1:0];
        q_item.top    = row_sel[ROW_W-1:0];
        q_item.bottom = bottom_w[ROW_W-1:0];
        q_item.left   = col_sel[COL_W-1:0];
        q_item.right  = right_w[COL_W-1:0];
        q_item.value  = s_tdata[VAL_LSB +: WORD_W];
    end

endmodule

### hw/rtl/iiav_fifo.sv
module iiav_fifo
    import iiav_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_item,
    output logic full,
    input  logic pop,
    output logic valid,
    output cmd_t head
);

    cmd_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full  = (count_reg == QCNT_W'(QDEPTH));
    assign valid = (count_reg != '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### hw/rtl/iiav_back.sv
module iiav_back
    import iiav_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  cmd_t              q_head,
    output logic              q_pop,
    output logic              ram_en,
    output logic              ram_we,
    output logic [ADDR_W-1:0] ram_addr,
    output logic [WORD_W-1:0] ram_wdata,
    input  logic [WORD_W-1:0] ram_rdata,
    output div_req_t          div_req,
    input  logic              div_ready
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_LAST = 2'd2;
    localparam logic [1:0] ST_HAND = 2'd3;

    // Corner read order; the last two corners are subtracted.
    localparam logic [1:0] CORNER_BR = 2'd0;
    localparam logic [1:0] CORNER_TL = 2'd1;
    localparam logic [1:0] CORNER_TR = 2'd2;
    localparam logic [1:0] CORNER_BL = 2'd3;

    logic [1:0]              state_reg;
    logic [1:0]              state_next;
    logic [1:0]              corner_reg;
    logic [1:0]              corner_next;
    cmd_t                    cur_reg;
    cmd_t                    cur_next;
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] sum_next;
    logic                    empty_reg;
    logic                    empty_next;
    logic signed [SUM_W-1:0] word_s;

    assign word_s = $signed({{(SUM_W - WORD_W){1'b0}}, ram_rdata});
    assign q_pop  = (state_reg == ST_IDLE) && q_valid;

    assign div_req.valid = (state_reg == ST_HAND);
    assign div_req.empty = empty_reg;
    assign div_req.sum   = sum_reg;

    always_comb
    begin
        state_next  = state_reg;
        corner_next = corner_reg;
        cur_next    = cur_reg;
        sum_next    = sum_reg;
        empty_next  = empty_reg;
        ram_en      = 1'b0;
        ram_we      = 1'b0;
        ram_addr    = '0;
        ram_wdata   = q_head.value;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_head.kind)
                        KIND_WRITE:
                        begin
                            ram_en   = 1'b1;
                            ram_we   = 1'b1;
                            ram_addr = store_addr(q_head.ch, q_head.top, q_head.left);
                        end
                        KIND_QUERY:
                        begin
                            cur_next    = q_head;
                            corner_next = CORNER_BR;
                            sum_next    = '0;
                            empty_next  = 1'b0;
                            state_next  = ST_READ;
                        end
                        KIND_EMPTY:
                        begin
                            sum_next   = '0;
                            empty_next = 1'b1;
                            state_next = ST_HAND;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                ram_en = 1'b1;
                case (corner_reg)
                    CORNER_BR: ram_addr = store_addr(cur_reg.ch, cur_reg.bottom, cur_reg.right);
                    CORNER_TL: ram_addr = store_addr(cur_reg.ch, cur_reg.top, cur_reg.left);
                    CORNER_TR: ram_addr = store_addr(cur_reg.ch, cur_reg.top, cur_reg.right);
                    CORNER_BL: ram_addr = store_addr(cur_reg.ch, cur_reg.bottom, cur_reg.left);
                    default:   ram_addr = '0;
                endcase
                // The word read in the previous cycle belongs to the previous corner.
                if (corner_reg == CORNER_BL)
                begin
                    sum_next = sum_reg - word_s;
                end
                else if (corner_reg != CORNER_BR)
                begin
                    sum_next = sum_reg + word_s;
                end
                corner_next = corner_reg + 2'd1;
                if (corner_reg == CORNER_BL)
                begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                sum_next   = sum_reg - word_s;
                state_next = ST_HAND;
            end
            ST_HAND:
            begin
                if (div_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            corner_reg <= CORNER_BR;
            empty_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            corner_reg <= corner_next;
            empty_reg  <= empty_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        sum_reg <= sum_next;
    end

endmodule

### hw/rtl/iiav_div.sv
module iiav_div
    import iiav_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  div_req_t                 req,
    output logic                     ready,
    input  logic [REG_W-1:0]         cell_size,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic signed [MEAN_W-1:0] mean,
    output logic                     in_range
);

    logic                     busy_reg;
    logic                     busy_next;
    logic [STEP_W-1:0]        step_reg;
    logic [STEP_W-1:0]        step_next;
    logic [QUO_W-1:0]         num_reg;
    logic [QUO_W-1:0]         num_next;
    logic [DEN_W-1:0]         rem_reg;
    logic [DEN_W-1:0]         rem_next;
    logic [DEN_W-1:0]         den_reg;
    logic [DEN_W-1:0]         den_next;
    logic                     neg_reg;
    logic                     neg_next;
    logic                     flag_reg;
    logic                     flag_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic signed [MEAN_W-1:0] out_mean_reg;
    logic signed [MEAN_W-1:0] out_mean_next;
    logic                     out_flag_reg;
    logic                     out_flag_next;
    logic [SUM_W-1:0]         mag;
    logic [QUO_W-1:0]         neg_num;
    logic signed [MEAN_W-1:0] sat_mean;

    assign ready    = !busy_reg;
    assign m_tvalid = out_valid_reg;
    assign mean     = out_mean_reg;
    assign in_range = out_flag_reg;

    assign mag     = req.sum[SUM_W-1] ? SUM_W'(-req.sum) : req.sum;
    assign neg_num = ~num_reg + QUO_W'(1);

    // Truncation toward zero is division of the magnitude; the sign comes back after.
    always_comb
    begin
        if (!neg_reg)
        begin
            sat_mean = (num_reg > MAG_POS_LIM) ? MEAN_MAX : $signed(num_reg[MEAN_W-1:0]);
        end
        else
        begin
            sat_mean = (num_reg > MAG_NEG_LIM) ? MEAN_MIN : $signed(neg_num[MEAN_W-1:0]);
        end
    end

    always_comb
    begin
        logic [DEN_W:0]   trial;
        logic [DEN_W-1:0] r;
        logic [QUO_W-1:0] n;
        busy_next      = busy_reg;
        step_next      = step_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        den_next       = den_reg;
        neg_next       = neg_reg;
        flag_next      = flag_reg;
        out_valid_next = out_valid_reg;
        out_mean_next  = out_mean_reg;
        out_flag_next  = out_flag_reg;
        r              = rem_reg;
        n              = num_reg;
        trial          = '0;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (!busy_reg)
        begin
            if (req.valid)
            begin
                busy_next = 1'b1;
                flag_next = !req.empty;
                neg_next  = req.sum[SUM_W-1];
                num_next  = req.empty ? '0 : QUO_W'({mag, {FRAC_W{1'b0}}});
                rem_next  = '0;
                den_next  = DEN_W'(cell_size) * DEN_W'(cell_size);
                step_next = req.empty ? '0 : STEP_W'(QUO_W / 2);
            end
        end
        else if (step_reg != '0)
        begin
            // Two restoring steps per cycle; quotient bits fill the vacated low end.
            for (int i = 0; i < 2; i++)
            begin
                trial = {r, n[QUO_W-1]};
                n     = {n[QUO_W-2:0], 1'b0};
                if (trial >= {1'b0, den_reg})
                begin
                    trial = trial - {1'b0, den_reg};
                    n[0]  = 1'b1;
                end
                r = trial[DEN_W-1:0];
            end
            num_next  = n;
            rem_next  = r;
            step_next = step_reg - STEP_W'(1);
        end
        else if (!out_valid_reg || m_tready)
        begin
            out_valid_next = 1'b1;
            out_mean_next  = sat_mean;
            out_flag_next  = flag_reg;
            busy_next      = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg      <= num_next;
        rem_reg      <= rem_next;
        den_reg      <= den_next;
        neg_reg      <= neg_next;
        flag_reg     <= flag_next;
        out_mean_reg <= out_mean_next;
        out_flag_reg <= out_flag_next;
    end

endmodule

### hw/rtl/integral_image_cell_mean_core.sv
// Integral-image cell mean. Load beats (tuser low) store one 32-bit integral word per beat at
// a pixel row, column and channel; query beats (tuser high) name an output cell and return
// one beat with the cell sum times 256 divided by the cell area, truncated toward zero and
// saturated to 41 signed bits, plus an in-range flag. A load makes one write through the
// single store port. A query holds the store port for its four corner reads, the read
// latency, the accumulate and the hand-off, and then goes to the divider, which retires
// two quotient bits per cycle over a 42-bit quotient and loads the output register; in
// steady state queries are therefore paced by the divider while the sink keeps up, since
// the divider takes no new sum while busy, while a two-entry command queue lets loads and
// the corner reads of the next query proceed underneath. A query outside the cell grid or
// the channel count skips the reads and the division and returns a zero mean with the flag
// clear. The store has no clearing pass: reset leaves it undefined and only words already
// loaded may be queried. Configuration must be written only while no beat is in flight;
// the block itself does not enforce this.
module integral_image_cell_mean_core
    import iiav_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    // Configuration write port.
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_data,

    // Command stream.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // From bit 0 up: ii_value[31:0], pos_row[38:32], pos_col[45:39], channel[47:46].
    input  logic [S_DATA_W-1:0]  s_tdata,
    // command: 0 loads one integral word, 1 queries one cell.
    input  logic                 s_tuser,

    // Result stream.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // From bit 0 up: mean_q8[40:0], then zero fill up to bit 47.
    output logic [M_DATA_W-1:0]  m_tdata,
    // in_range.
    output logic                 m_tuser
);

    logic [REG_W-1:0]         height_reg;
    logic [REG_W-1:0]         width_reg;
    logic [REG_W-1:0]         cell_reg;
    logic [CHANS_W-1:0]       chans_reg;
    cfg_t                     cfg;

    logic                     q_push;
    cmd_t                     q_item;
    logic                     q_full;
    logic                     q_pop;
    logic                     q_valid;
    cmd_t                     q_head;

    logic                     ram_en;
    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_addr;
    logic [WORD_W-1:0]        ram_wdata;
    logic [WORD_W-1:0]        ram_rdata;

    div_req_t                 div_req;
    logic                     div_ready;
    logic signed [MEAN_W-1:0] mean;
    logic                     in_range;

    // Configuration registers; an index past the list leaves them all alone.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            height_reg <= HEIGHT_RESET;
            width_reg  <= WIDTH_RESET;
            cell_reg   <= CELL_RESET;
            chans_reg  <= CHANNELS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_HEIGHT:   height_reg <= cfg_data;
                REG_WIDTH:    width_reg  <= cfg_data;
                REG_CELL:     cell_reg   <= cfg_data;
                REG_CHANNELS: chans_reg  <= cfg_data[CHANS_W-1:0];
                default:      height_reg <= height_reg;
            endcase
        end
    end

    assign cfg.height    = height_reg;
    assign cfg.width     = width_reg;
    assign cfg.cell_size = cell_reg;
    assign cfg.chans     = chans_reg;

    // The front end checks the grid and works out the four corners in the accept cycle.
    iiav_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cfg      (cfg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (q_item)
    );

    iiav_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_item),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    // The back end owns the store port, so loads and corner reads stay in beat order.
    iiav_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .ram_en    (ram_en),
        .ram_we    (ram_we),
        .ram_addr  (ram_addr),
        .ram_wdata (ram_wdata),
        .ram_rdata (ram_rdata),
        .div_req   (div_req),
        .div_ready (div_ready)
    );

    iiav_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Divider with its own output register, so a finished mean can wait for the sink.
    iiav_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (div_req),
        .ready     (div_ready),
        .cell_size (cell_reg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .mean      (mean),
        .in_range  (in_range)
    );

    assign m_tdata = {{(M_DATA_W - MEAN_W){1'b0}}, mean};
    assign m_tuser = in_range;

    // An out-of-range beat always carries a zero mean.
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("out-of-range result with nonzero mean");

    // The back end never pops an empty queue.
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("command queue popped while empty");

    // A sum offered to a busy divider stays put until it is taken.
    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.valid && !div_ready |=> div_req.valid && $stable(div_req.sum))
        else $error("divider request dropped or changed while stalled");

endmodule
